@@ design/sorted_score_table_unit_defines.svh @@
// Assertion macros for the sorted score table.
// Both macros sample on the rising edge of clk and are disabled while rst_n is low.
`ifndef SORTED_SCORE_TABLE_UNIT_DEFINES_SVH
`define SORTED_SCORE_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check that a property holds.
`define SST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds.
`define SST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define SST_ASSERT(lbl, prop, msg)
`define SST_NEVER(lbl, expr, msg)
`endif

`endif

@@ design/sst_pkg.sv @@
`timescale 1ns / 1ps

package sst_pkg;

  localparam int TAG_W   = 16;
  localparam int SCORE_W = 10;
  localparam int FILL_W  = 5;
  localparam int RANK_W  = 4;

  // One table entry
  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] secondary;
    logic [SCORE_W-1:0] primary;
  } entry_t;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DEL_MIN  = 2'd1,
    OP_DEL_TAIL = 2'd2,
    OP_READ     = 2'd3
  } sst_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } sst_status_t;

  // Control states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } sst_state_t;

  // What every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_ROTATE,
    CELL_REMOVE
  } cell_mode_t;

  // Control broadcast to the cell chain
  typedef struct packed {
    cell_mode_t mode;
    entry_t     entry;
  } cell_ctl_t;

endpackage

@@ design/sst_cell.sv @@
`timescale 1ns / 1ps

module sst_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  sst_pkg::cell_ctl_t  ctl_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic [IDX_W-1:0]    last_i,
  input  logic [IDX_W-1:0]    pos_i,
  input  sst_pkg::entry_t     left_i,
  input  sst_pkg::entry_t     right_i,
  input  sst_pkg::entry_t     head_i,
  input  logic                greater_left_i,
  output sst_pkg::entry_t     q_o,
  output logic                greater_o
);

  sst_pkg::entry_t q_r;
  sst_pkg::entry_t q_nxt;
  logic            occupied;

  // Flag a held entry that ranks strictly ahead of the new one
  assign occupied  = CNT_W'(IDX) < count_i;
  assign greater_o = occupied && (q_r.primary > ctl_i.entry.primary);
  assign q_o       = q_r;

  // Select the next content of this cell
  always_comb begin
    q_nxt = q_r;
    case (ctl_i.mode)
      sst_pkg::CELL_INSERT: begin
        if (greater_o) begin
          q_nxt = q_r;
        end else if (greater_left_i) begin
          q_nxt = ctl_i.entry;
        end else begin
          q_nxt = left_i;
        end
      end
      sst_pkg::CELL_ROTATE: begin
        q_nxt = (IDX_W'(IDX) == last_i) ? head_i : right_i;
      end
      sst_pkg::CELL_REMOVE: begin
        q_nxt = (IDX_W'(IDX) >= pos_i) ? right_i : q_r;
      end
      default: q_nxt = q_r;
    endcase
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule

@@ design/sorted_score_table_unit.sv @@
`timescale 1ns / 1ps
`include "sorted_score_table_unit_defines.svh"

// Sorted score table: up to DEPTH entries held in a chain of cells, ranked by
// descending primary score. An item is taken when start is high and busy is
// low, and its one result appears on the out_ ports for a single cycle with
// out_valid high; the receiver must take it then, as nothing holds it back.
// Insert, and any item answered with a status alone (full, empty, rank out of
// range), gives its result the cycle after it is taken and leaves busy low, so
// such items can follow every cycle. Read and both deletes rotate the whole
// chain once past the comparator at cell 0, one cell per cycle, in the scan
// state and then give their result from the finish state; busy stays high
// until the result is shown, so no next item is taken before it.
module sorted_score_table_unit #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_tag,
  input  logic [9:0]  in_secondary_score,
  input  logic [9:0]  in_primary_score,
  input  logic [3:0]  in_rank,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [15:0] out_tag,
  output logic [9:0]  out_secondary,
  output logic [9:0]  out_primary,
  output logic [4:0]  out_fill
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int RW    = (CNT_W > sst_pkg::RANK_W) ? CNT_W : sst_pkg::RANK_W;
  localparam int FW    = (CNT_W > sst_pkg::FILL_W) ? CNT_W : sst_pkg::FILL_W;

  sst_pkg::sst_state_t  state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [IDX_W-1:0]     j_r, j_nxt;
  logic [IDX_W-1:0]     pos_r, pos_nxt;
  sst_pkg::sst_op_t     op_r, op_nxt;
  logic [3:0]           rank_r, rank_nxt;
  sst_pkg::entry_t      cap_r, cap_nxt;

  logic                 out_valid_r;
  sst_pkg::sst_status_t out_status_r;
  sst_pkg::entry_t      out_entry_r;
  logic [4:0]           out_fill_r;

  logic                 res_valid;
  sst_pkg::sst_status_t res_status;
  sst_pkg::entry_t      res_entry;
  logic [FW-1:0]        fill_wide;

  sst_pkg::cell_ctl_t   ctl;
  sst_pkg::entry_t      cell_q [DEPTH];
  logic                 greater [DEPTH];
  sst_pkg::entry_t      head;
  sst_pkg::entry_t      new_entry;
  sst_pkg::sst_op_t     op_in;

  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  logic                 rank_bad;
  logic                 scan_go;
  logic                 scan_done;
  logic [IDX_W-1:0]     last_idx;

  // Decode the handshake and table status
  assign busy      = (state_r != sst_pkg::S_IDLE);
  assign accept    = start && !busy;
  assign op_in     = sst_pkg::sst_op_t'(in_op);
  assign is_full   = (count_r == CNT_W'(DEPTH));
  assign is_empty  = (count_r == '0);
  assign rank_bad  = (RW'(in_rank) >= RW'(count_r));
  assign scan_go   = accept && (op_in != sst_pkg::OP_INSERT) && !is_empty &&
                     !((op_in == sst_pkg::OP_READ) && rank_bad);
  assign last_idx  = IDX_W'(count_r - CNT_W'(1));
  assign scan_done = (j_r == last_idx);
  assign head      = cell_q[0];

  assign new_entry.tag       = in_tag;
  assign new_entry.secondary = in_secondary_score;
  assign new_entry.primary   = in_primary_score;

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    sst_pkg::entry_t left_d;
    sst_pkg::entry_t right_d;
    logic            greater_left_d;

    if (i == 0) begin : g_first
      assign left_d         = new_entry;
      assign greater_left_d = 1'b0;
    end else begin : g_inner
      assign left_d         = cell_q[i-1];
      assign greater_left_d = greater[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[0];
    end else begin : g_mid
      assign right_d = cell_q[i+1];
    end

    sst_cell #(
      .IDX   (i),
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk            (clk),
      .ctl_i          (ctl),
      .count_i        (count_r),
      .last_i         (last_idx),
      .pos_i          (pos_r),
      .left_i         (left_d),
      .right_i        (right_d),
      .head_i         (head),
      .greater_left_i (greater_left_d),
      .q_o            (cell_q[i]),
      .greater_o      (greater[i])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sst_pkg::S_IDLE:   state_nxt = scan_go ? sst_pkg::S_SCAN : sst_pkg::S_IDLE;
      sst_pkg::S_SCAN:   state_nxt = scan_done ? sst_pkg::S_FINISH : sst_pkg::S_SCAN;
      sst_pkg::S_FINISH: state_nxt = sst_pkg::S_IDLE;
      default:           state_nxt = sst_pkg::S_IDLE;
    endcase
  end

  // Cell control, scan capture and result
  always_comb begin
    logic take;
    take       = 1'b0;
    ctl.mode   = sst_pkg::CELL_HOLD;
    ctl.entry  = new_entry;
    count_nxt  = count_r;
    j_nxt      = j_r;
    pos_nxt    = pos_r;
    op_nxt     = op_r;
    rank_nxt   = rank_r;
    cap_nxt    = cap_r;
    res_valid  = 1'b0;
    res_status = sst_pkg::STAT_OK;
    res_entry  = '0;
    unique case (state_r)
      sst_pkg::S_IDLE: begin
        if (accept) begin
          op_nxt   = op_in;
          rank_nxt = in_rank;
          j_nxt    = '0;
          case (op_in) inside
            sst_pkg::OP_INSERT: begin
              res_valid = 1'b1;
              if (is_full) begin
                res_status = sst_pkg::STAT_FULL;
              end else begin
                ctl.mode  = sst_pkg::CELL_INSERT;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            sst_pkg::OP_DEL_MIN, sst_pkg::OP_DEL_TAIL, sst_pkg::OP_READ: begin
              if (is_empty) begin
                res_valid  = 1'b1;
                res_status = sst_pkg::STAT_EMPTY;
              end else if ((op_in == sst_pkg::OP_READ) && rank_bad) begin
                res_valid  = 1'b1;
                res_status = sst_pkg::STAT_RANGE;
              end
            end
            default: res_valid = 1'b0;
          endcase
        end
      end
      sst_pkg::S_SCAN: begin
        // Rotate the chain once and watch the entry passing cell 0
        ctl.mode = sst_pkg::CELL_ROTATE;
        j_nxt    = j_r + IDX_W'(1);
        case (op_r)
          sst_pkg::OP_DEL_MIN:  take = (j_r == '0) || (head.secondary < cap_r.secondary);
          sst_pkg::OP_DEL_TAIL: take = scan_done;
          sst_pkg::OP_READ:     take = (RW'(j_r) == RW'(rank_r));
          default:              take = 1'b0;
        endcase
        if (take) begin
          cap_nxt = head;
          pos_nxt = j_r;
        end
      end
      sst_pkg::S_FINISH: begin
        res_valid = 1'b1;
        res_entry = cap_r;
        if (op_r != sst_pkg::OP_READ) begin
          ctl.mode  = sst_pkg::CELL_REMOVE;
          count_nxt = count_r - CNT_W'(1);
        end
      end
      default: res_valid = 1'b0;
    endcase
  end

  assign fill_wide = FW'(count_nxt);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sst_pkg::S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= res_valid;
    end
  end

  // Scan and result payload
  always_ff @(posedge clk) begin
    j_r    <= j_nxt;
    pos_r  <= pos_nxt;
    op_r   <= op_nxt;
    rank_r <= rank_nxt;
    cap_r  <= cap_nxt;
    if (res_valid) begin
      out_status_r <= res_status;
      out_entry_r  <= res_entry;
      out_fill_r   <= fill_wide[4:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_tag       = out_entry_r.tag;
  assign out_secondary = out_entry_r.secondary;
  assign out_primary   = out_entry_r.primary;
  assign out_fill      = out_fill_r;

  `SST_NEVER(a_count_bound, count_r > CNT_W'(DEPTH), "entry count above depth")
  `SST_NEVER(a_scan_empty, (state_r == sst_pkg::S_SCAN) && is_empty, "scan on empty table")
  `SST_ASSERT(a_insert_grows,
              (accept && (op_in == sst_pkg::OP_INSERT) && !is_full) |=>
              (out_valid_r && (count_r == $past(count_r) + 1'b1)),
              "insert did not add one entry")
  `SST_ASSERT(a_finish_result,
              (state_r == sst_pkg::S_FINISH) |=>
              (out_valid_r && (state_r == sst_pkg::S_IDLE)),
              "scan finished without result")
  `SST_ASSERT(a_remove_shrinks,
              ((state_r == sst_pkg::S_FINISH) && (op_r != sst_pkg::OP_READ)) |=>
              (count_r == $past(count_r) - 1'b1),
              "delete did not drop one entry")

endmodule

@@ bench/sorted_score_table_unit_tb.sv @@
`timescale 1ns / 1ps

module sorted_score_table_unit_tb;
  import sst_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = DEPTH + 6;

  // One expected result of the table
  typedef struct packed {
    sst_status_t        status;
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] secondary;
    logic [SCORE_W-1:0] primary;
    logic [FILL_W-1:0]  fill;
  } table_result_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_op;
  logic [15:0]        in_tag;
  logic [9:0]         in_secondary_score;
  logic [9:0]         in_primary_score;
  logic [3:0]         in_rank;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [15:0]        out_tag;
  logic [9:0]         out_secondary;
  logic [9:0]         out_primary;
  logic [4:0]         out_fill;

  // Shadow copy of the table, in rank order
  entry_t        shadow_entries [DEPTH];
  int            shadow_count;
  table_result_t pending_results [$];
  table_result_t oldest_result;
  int            mismatch_count;
  int            cycle_count;
  int            send_idle_pct;

  sorted_score_table_unit #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_tag            (in_tag),
    .in_secondary_score(in_secondary_score),
    .in_primary_score  (in_primary_score),
    .in_rank           (in_rank),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_tag           (out_tag),
    .out_secondary     (out_secondary),
    .out_primary       (out_primary),
    .out_fill          (out_fill)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow table and return its result
  function automatic table_result_t apply_table_op(sst_op_t op, logic [15:0] item_tag,
                                                   logic [9:0] item_sec, logic [9:0] item_pri,
                                                   logic [3:0] item_rank);
    table_result_t res;
    int            pos;
    res        = '0;
    res.status = STAT_OK;
    if (op == OP_INSERT) begin
      if (shadow_count >= DEPTH) begin
        res.status = STAT_FULL;
      end else begin
        // land behind every strictly greater primary score
        pos = 0;
        while (pos < shadow_count && shadow_entries[pos].primary > item_pri) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[pos].tag       = item_tag;
        shadow_entries[pos].secondary = item_sec;
        shadow_entries[pos].primary   = item_pri;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = STAT_EMPTY;
    end else if (op == OP_READ) begin
      if (item_rank >= shadow_count) begin
        res.status = STAT_RANGE;
      end else begin
        res.tag       = shadow_entries[item_rank].tag;
        res.secondary = shadow_entries[item_rank].secondary;
        res.primary   = shadow_entries[item_rank].primary;
      end
    end else begin
      // pick the tail, or the first entry holding the lowest secondary score
      if (op == OP_DEL_TAIL) begin
        pos = shadow_count - 1;
      end else begin
        pos = 0;
        for (int i = 1; i < shadow_count; i++)
          if (shadow_entries[i].secondary < shadow_entries[pos].secondary) pos = i;
      end
      res.tag       = shadow_entries[pos].tag;
      res.secondary = shadow_entries[pos].secondary;
      res.primary   = shadow_entries[pos].primary;
      for (int i = pos; i + 1 < shadow_count; i++) shadow_entries[i] = shadow_entries[i+1];
      shadow_count--;
    end
    res.fill = shadow_count[4:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < 40)
      $display("MISMATCH at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  // Present one item, hold it until taken, then record its expected result
  task automatic send_item(sst_op_t op, logic [15:0] item_tag, logic [9:0] item_sec,
                           logic [9:0] item_pri, logic [3:0] item_rank);
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start              <= 1'b1;
    in_op              <= op;
    in_tag             <= item_tag;
    in_secondary_score <= item_sec;
    in_primary_score   <= item_pri;
    in_rank            <= item_rank;
    do @(posedge clk); while (busy !== 1'b0);
    pending_results.push_back(apply_table_op(op, item_tag, item_sec, item_pri, item_rank));
  endtask

  // Check each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, status", 32'(out_status), 32'(0));
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_status !== oldest_result.status)
          report_mismatch("status", 32'(out_status), 32'(oldest_result.status));
        if (out_tag !== oldest_result.tag)
          report_mismatch("tag", 32'(out_tag), 32'(oldest_result.tag));
        if (out_secondary !== oldest_result.secondary)
          report_mismatch("secondary", 32'(out_secondary), 32'(oldest_result.secondary));
        if (out_primary !== oldest_result.primary)
          report_mismatch("primary", 32'(out_primary), 32'(oldest_result.primary));
        if (out_fill !== oldest_result.fill)
          report_mismatch("fill", 32'(out_fill), 32'(oldest_result.fill));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Deletes and reads on an empty table
  task automatic test_empty_table();
    send_item(OP_DEL_MIN, 16'h1111, 10'd5, 10'd5, 4'd0);
    send_item(OP_DEL_TAIL, 16'h2222, 10'd5, 10'd5, 4'd0);
    send_item(OP_READ, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_READ, 16'hffff, 10'h3ff, 10'h3ff, 4'd15);
  endtask

  // Extreme field values, a tie with the head, reads in and out of range
  task automatic test_insert_extremes();
    send_item(OP_INSERT, 16'hffff, 10'd1023, 10'd999, 4'd0);
    send_item(OP_INSERT, 16'h0000, 10'd0, 10'd0, 4'd15);
    send_item(OP_INSERT, 16'ha5a5, 10'd512, 10'd999, 4'd0);
    send_item(OP_INSERT, 16'h5a5a, 10'd0, 10'd1023, 4'd0);
    send_item(OP_READ, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_READ, 16'h0000, 10'd0, 10'd0, 4'd1);
    send_item(OP_READ, 16'h0000, 10'd0, 10'd0, 4'd3);
    send_item(OP_READ, 16'h0000, 10'd0, 10'd0, 4'd4);
    send_item(OP_READ, 16'h0000, 10'd0, 10'd0, 4'd15);
  endtask

  // Tie on the lowest secondary score, tail removal down to empty
  task automatic test_delete_order();
    send_item(OP_DEL_MIN, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_DEL_TAIL, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_DEL_MIN, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_DEL_TAIL, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_DEL_TAIL, 16'h0000, 10'd0, 10'd0, 4'd0);
    send_item(OP_INSERT, 16'h1234, 10'd1000, 10'd1000, 4'd0);
    send_item(OP_DEL_MIN, 16'h0000, 10'd0, 10'd0, 4'd0);
  endtask

  // Bursts that lean toward filling or draining the table, with narrow score
  // ranges now and then so that ties are common
  task automatic test_random_traffic(int item_total, int idle_pct);
    int         insert_pct;
    int         pri_span;
    int         sec_span;
    sst_op_t    op;
    logic [3:0] rank;
    send_idle_pct = idle_pct;
    insert_pct    = 50;
    pri_span      = 1023;
    sec_span      = 1023;
    for (int k = 0; k < item_total; k++) begin
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 50;
          default: insert_pct = 15;
        endcase
        pri_span = $urandom_range(1) ? 7 : 1023;
        sec_span = $urandom_range(1) ? 3 : 1023;
      end
      if ($urandom_range(99) < insert_pct) op = OP_INSERT;
      else op = sst_op_t'($urandom_range(3, 1));
      if (shadow_count > 0 && $urandom_range(99) < 80) begin
        rank = 4'($urandom_range(shadow_count - 1));
      end else begin
        rank = 4'($urandom_range(15));
      end
      send_item(op, 16'($urandom), 10'($urandom_range(sec_span)),
                10'($urandom_range(pri_span)), rank);
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_op              <= OP_INSERT;
    in_tag             <= '0;
    in_secondary_score <= '0;
    in_primary_score   <= '0;
    in_rank            <= '0;
    shadow_count   = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    send_idle_pct  = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 30;
    test_empty_table();
    test_insert_extremes();
    test_delete_order();
    test_random_traffic(460, 30);
    test_random_traffic(460, 78);
    test_random_traffic(460, 0);

    // drain outstanding results
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ sorted_score_table_unit.f @@
+incdir+design
design/sst_pkg.sv
design/sst_cell.sv
design/sorted_score_table_unit.sv
bench/sorted_score_table_unit_tb.sv
